// File: sv/cdsc_pkg.sv
// Package with the request types, field widths and register codes of the cepstral delta core.
package cdsc_pkg;

    localparam int COEF_BITS    = 24;
    localparam int INDEX_W      = 5;
    localparam int FRAME_NUM_W  = 24;
    localparam int POWER_W      = 48;
    localparam int STAB_W       = 32;
    localparam int SEQ_W        = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 5;

    localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_WINDOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INCLUDE_ENERGY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COEFS      = 2'd2;

    localparam logic [4:0] HALF_WINDOW_RESET = 5'd2;
    localparam logic [4:0] NUM_COEFS_RESET   = 5'd12;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] coef_value;
        logic [INDEX_W-1:0]          coef_index;
        logic                        end_of_sequence;
    } coef_item_t;

    typedef struct packed {
        logic [FRAME_NUM_W-1:0] frame_number;
        logic [POWER_W-1:0]     delta_power;
        logic [STAB_W-1:0]      stability;
        logic                   final_result;
    } result_item_t;

endpackage

// File: sv/cepstral_delta_and_stability_core.sv
// Top level of the cepstral delta power and spectral stability core.
// Coefficients are stored in a frame ring of 2*MAX_HALF_WINDOW+1 frames of MAX_COEFS+1
// words, held in one memory with two registered read ports and one write port. A request
// that opens a new frame first zeroes all MAX_COEFS+1 words of its slot. A request that
// completes a frame then produces its results one at a time, each with n-frame regression
// over K coefficients. The shared divider yields one quotient bit per cycle and the
// square-root unit one root bit per cycle. Results that need no arithmetic (first and last
// frames, or no coefficients selected) skip the divider and the square-root unit.
module cepstral_delta_and_stability_core #(
    parameter int MAX_HALF_WINDOW = 16,
    parameter int MAX_COEFS       = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             coef_valid,
    output logic                             coef_ready,
    input  cdsc_pkg::coef_item_t             coef,
    output logic                             result_valid,
    input  logic                             result_ready,
    output cdsc_pkg::result_item_t           result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cdsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cdsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cdsc_pkg::*;

    localparam int RING      = 2 * MAX_HALF_WINDOW + 1;
    localparam int WORDS     = MAX_COEFS + 1;
    localparam int DEPTH     = RING * WORDS;
    localparam int SLOT_W    = $clog2(RING);
    localparam int WORD_W    = $clog2(WORDS);
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int HW_W      = $clog2(MAX_HALF_WINDOW + 1);
    localparam int MAX_JSUM  = MAX_HALF_WINDOW * (MAX_HALF_WINDOW + 1) / 2;
    localparam int MAX_SUMSQ = MAX_HALF_WINDOW * (MAX_HALF_WINDOW + 1)
                               * (2 * MAX_HALF_WINDOW + 1) / 6;
    localparam int DIFF_W    = COEF_BITS + 1;
    localparam int PROD_W    = HW_W + 1 + DIFF_W;
    localparam int S_W       = DIFF_W + $clog2(MAX_JSUM + 1) + 1;
    localparam int SQS_W     = $clog2(MAX_SUMSQ + 1);
    localparam int DV_W      = SQS_W + 1;
    localparam int NUM_W     = S_W;
    localparam int DC_W      = $clog2(NUM_W);
    localparam int SQI_W     = COEF_BITS + 1;
    localparam int SQ_W      = 2 * SQI_W;
    localparam int PACC_W    = 2 * COEF_BITS + $clog2(WORDS + 1);
    localparam int DACC_W    = 2 * DIFF_W + $clog2(WORDS + 1);
    localparam int RAD_W     = DACC_W + (DACC_W % 2);
    localparam int ROOT_W    = RAD_W / 2;
    localparam int RC_W      = $clog2(ROOT_W);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_CLEAR = 15'b000000000000010,
        ST_PUT   = 15'b000000000000100,
        ST_NEXT  = 15'b000000000001000,
        ST_SUMSQ = 15'b000000000010000,
        ST_DRD   = 15'b000000000100000,
        ST_DACC  = 15'b000000001000000,
        ST_DPREP = 15'b000000010000000,
        ST_DIV   = 15'b000000100000000,
        ST_SQ    = 15'b000001000000000,
        ST_PADD  = 15'b000010000000000,
        ST_XRD   = 15'b000100000000000,
        ST_XDIF  = 15'b001000000000000,
        ST_XADD  = 15'b010000000000000,
        ST_ROOT  = 15'b100000000000000
    } state_t;

    logic signed [COEF_BITS-1:0] ring_mem [DEPTH];

    state_t                   state_reg, state_next;
    logic [4:0]               half_window_reg, half_window_next;
    logic                     include_energy_reg, include_energy_next;
    logic [4:0]               num_coefs_reg, num_coefs_next;
    logic [SLOT_W-1:0]        newest_reg, newest_next;
    logic                     frame_open_reg, frame_open_next;
    logic [FRAME_NUM_W-1:0]   frames_received_reg, frames_received_next;
    logic [FRAME_NUM_W-1:0]   frames_emitted_reg, frames_emitted_next;
    logic [SEQ_W-1:0]         seq_count_reg, seq_count_next;
    logic                     flush_reg, flush_next;
    logic                     emit_reg, emit_next;
    logic [HW_W-1:0]          hw_eff_reg, hw_eff_next;
    logic [WORD_W-1:0]        nc_eff_reg, nc_eff_next;
    logic signed [COEF_BITS-1:0] val_reg, val_next;
    logic [INDEX_W-1:0]       idx_reg, idx_next;
    logic                     eos_reg, eos_next;
    logic [WORD_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [HW_W-1:0]          back_reg, back_next;
    logic [HW_W-1:0]          n_reg, n_next;
    logic [HW_W-1:0]          j_reg, j_next;
    logic [WORD_W-1:0]        k_reg, k_next;
    logic                     fin_reg, fin_next;
    logic                     pass_reg, pass_next;
    logic                     xmode_reg, xmode_next;
    logic [SQS_W-1:0]         sumsq_reg, sumsq_next;
    logic signed [S_W-1:0]    s_acc_reg, s_acc_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [DV_W-1:0]          rem_reg, rem_next;
    logic [DC_W-1:0]          div_cnt_reg, div_cnt_next;
    logic [SQI_W-1:0]         sq_in_reg, sq_in_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [PACC_W-1:0]        power_reg, power_next;
    logic [DACC_W-1:0]        dacc_reg, dacc_next;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    logic [ROOT_W+1:0]        rrem_reg, rrem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [RC_W-1:0]          root_cnt_reg, root_cnt_next;
    logic [ROOT_W:0]          dist_sum_reg, dist_sum_next;
    logic                     result_valid_reg, result_valid_next;
    result_item_t             result_reg, result_next;
    logic signed [COEF_BITS-1:0] rd_a_reg, rd_b_reg;

    logic [HW_W-1:0]          hw_live;
    logic [WORD_W-1:0]        nc_live;
    logic [WORD_W-1:0]        first_k;
    logic [FRAME_NUM_W-1:0]   pend;
    logic [FRAME_NUM_W-1:0]   back_full;
    logic [FRAME_NUM_W-1:0]   seq_ext;
    logic [FRAME_NUM_W-1:0]   left_full;
    logic [FRAME_NUM_W-1:0]   lag;
    logic [FRAME_NUM_W-1:0]   n_full;
    logic                     go_emit;
    logic                     trivial;
    logic                     mem_we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [COEF_BITS-1:0] wdata;
    logic [SLOT_W-1:0]        off_a, off_b;
    logic [ADDR_W-1:0]        raddr_a, raddr_b;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic [S_W-1:0]           mag;
    logic [DV_W:0]            div_shift;
    logic                     div_ge;
    logic [ROOT_W+1:0]        root_shift;
    logic [ROOT_W+1:0]        root_trial;
    logic                     root_ge;
    logic [ROOT_W:0]          stab_full;
    logic                     idx_in_range;
    logic                     idx_closes;
    logic                     coef_accept;

    function automatic logic [ADDR_W-1:0] word_addr(
        input logic [SLOT_W-1:0] newest,
        input logic [SLOT_W-1:0] off,
        input logic [WORD_W-1:0] k
    );
        logic [SLOT_W:0] slot;
        if ({1'b0, newest} >= {1'b0, off})
            slot = {1'b0, newest} - {1'b0, off};
        else
            slot = {1'b0, newest} + (SLOT_W + 1)'(RING) - {1'b0, off};
        return ADDR_W'(int'(slot) * WORDS + int'(k));
    endfunction

    assign hw_live = (half_window_reg == '0) ? HW_W'(1)
                   : (int'(half_window_reg) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                   : HW_W'(half_window_reg);
    assign nc_live = (int'(num_coefs_reg) > MAX_COEFS) ? WORD_W'(MAX_COEFS)
                   : WORD_W'(num_coefs_reg);
    assign first_k = include_energy_reg ? '0 : WORD_W'(1);

    assign pend      = frames_received_reg - frames_emitted_reg;
    assign back_full = pend - FRAME_NUM_W'(1);
    assign seq_ext   = FRAME_NUM_W'(seq_count_reg);
    assign left_full = (seq_ext >= pend) ? seq_ext - pend : '0;
    assign lag       = (left_full == '0) ? FRAME_NUM_W'(1)
                     : (left_full < FRAME_NUM_W'(hw_eff_reg)) ? left_full
                     : FRAME_NUM_W'(hw_eff_reg);
    assign go_emit   = (pend != '0) && (flush_reg || back_full >= lag);
    assign n_full    = (FRAME_NUM_W'(hw_eff_reg) < left_full)
                     ? ((FRAME_NUM_W'(hw_eff_reg) < back_full) ? FRAME_NUM_W'(hw_eff_reg)
                                                               : back_full)
                     : ((left_full < back_full) ? left_full : back_full);
    assign trivial   = (left_full == '0) || (back_full == '0)
                     || (!include_energy_reg && nc_eff_reg == '0);

    assign idx_in_range = int'(idx_reg) <= int'(nc_eff_reg);
    assign idx_closes   = (int'(idx_reg) == int'(nc_eff_reg)) || eos_reg;

    assign mem_we = (state_reg == ST_CLEAR) || (state_reg == ST_PUT && idx_in_range);
    assign waddr  = word_addr(newest_reg, '0,
                              (state_reg == ST_CLEAR) ? clr_cnt_reg : WORD_W'(idx_reg));
    assign wdata  = (state_reg == ST_CLEAR) ? '0 : val_reg;

    assign off_a = (state_reg == ST_XRD) ? SLOT_W'(back_reg)
                 : SLOT_W'(back_reg) - SLOT_W'(j_reg);
    assign off_b = (state_reg == ST_XRD)
                 ? (pass_reg ? SLOT_W'(back_reg) - SLOT_W'(1) : SLOT_W'(back_reg) + SLOT_W'(1))
                 : SLOT_W'(back_reg) + SLOT_W'(j_reg);
    assign raddr_a = word_addr(newest_reg, off_a, k_reg);
    assign raddr_b = word_addr(newest_reg, off_b, k_reg);

    assign diff = DIFF_W'(rd_a_reg) - DIFF_W'(rd_b_reg);
    assign prod = $signed({1'b0, j_reg}) * diff;
    assign mag  = s_acc_reg[S_W-1] ? S_W'(-s_acc_reg) : S_W'(s_acc_reg);

    assign div_shift = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, sumsq_reg, 1'b0};

    assign root_shift = {rrem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign root_trial = {root_reg, 2'b01};
    assign root_ge    = root_shift >= root_trial;

    assign stab_full = dist_sum_reg >> 1;

    assign coef_accept  = coef_valid && coef_ready;
    assign coef_ready   = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[waddr] <= wdata;
        end
        rd_a_reg <= ring_mem[raddr_a];
        rd_b_reg <= ring_mem[raddr_b];
    end

    always_comb
    begin
        state_next           = state_reg;
        half_window_next     = half_window_reg;
        include_energy_next  = include_energy_reg;
        num_coefs_next       = num_coefs_reg;
        newest_next          = newest_reg;
        frame_open_next      = frame_open_reg;
        frames_received_next = frames_received_reg;
        frames_emitted_next  = frames_emitted_reg;
        seq_count_next       = seq_count_reg;
        flush_next           = flush_reg;
        emit_next            = emit_reg;
        hw_eff_next          = hw_eff_reg;
        nc_eff_next          = nc_eff_reg;
        val_next             = val_reg;
        idx_next             = idx_reg;
        eos_next             = eos_reg;
        clr_cnt_next         = clr_cnt_reg;
        back_next            = back_reg;
        n_next               = n_reg;
        j_next               = j_reg;
        k_next               = k_reg;
        fin_next             = fin_reg;
        pass_next            = pass_reg;
        xmode_next           = xmode_reg;
        sumsq_next           = sumsq_reg;
        s_acc_next           = s_acc_reg;
        num_next             = num_reg;
        rem_next             = rem_reg;
        div_cnt_next         = div_cnt_reg;
        sq_in_next           = sq_in_reg;
        sq_next              = sq_reg;
        power_next           = power_reg;
        dacc_next            = dacc_reg;
        rad_next             = rad_reg;
        rrem_next            = rrem_reg;
        root_next            = root_reg;
        root_cnt_next        = root_cnt_reg;
        dist_sum_next        = dist_sum_reg;
        result_valid_next    = result_valid_reg;
        result_next          = result_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HALF_WINDOW:    half_window_next    = cfg_data;
                CFG_INCLUDE_ENERGY: include_energy_next = cfg_data[0];
                CFG_NUM_COEFS:      num_coefs_next      = cfg_data;
                default:            ;
            endcase
        end

        // A finished result waits here until the output register is free.
        if (emit_reg && (!result_valid_reg || result_ready))
        begin
            result_next.frame_number = frames_emitted_reg;
            result_next.delta_power  = ((power_reg >> POWER_W) != '0) ? '1
                                     : POWER_W'(power_reg);
            result_next.stability    = ((stab_full >> STAB_W) != '0) ? '1
                                     : STAB_W'(stab_full);
            result_next.final_result = fin_reg;
            result_valid_next        = 1'b1;
            frames_emitted_next      = frames_emitted_reg + FRAME_NUM_W'(1);
            emit_next                = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (coef_accept)
                begin
                    val_next    = coef.coef_value;
                    idx_next    = coef.coef_index;
                    eos_next    = coef.end_of_sequence;
                    hw_eff_next = hw_live;
                    nc_eff_next = nc_live;
                    if (int'(coef.coef_index) > int'(nc_live) && !coef.end_of_sequence)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!frame_open_reg)
                    begin
                        newest_next  = (int'(newest_reg) == RING - 1) ? '0
                                     : newest_reg + SLOT_W'(1);
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_PUT;
                    end
                end
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + WORD_W'(1);
                if (clr_cnt_reg == WORD_W'(WORDS - 1))
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                frame_open_next = 1'b1;
                state_next      = ST_IDLE;
                if (idx_closes)
                begin
                    frame_open_next      = 1'b0;
                    frames_received_next = frames_received_reg + FRAME_NUM_W'(1);
                    if (seq_count_reg != SEQ_MAX)
                    begin
                        seq_count_next = seq_count_reg + SEQ_W'(1);
                    end
                    flush_next = eos_reg;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (!emit_reg)
                begin
                    if (go_emit)
                    begin
                        back_next     = HW_W'(back_full);
                        n_next        = HW_W'(n_full);
                        fin_next      = flush_reg && (back_full == '0);
                        power_next    = '0;
                        dist_sum_next = '0;
                        sumsq_next    = '0;
                        j_next        = HW_W'(1);
                        k_next        = first_k;
                        s_acc_next    = '0;
                        if (trivial)
                        begin
                            emit_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SUMSQ;
                        end
                    end
                    else
                    begin
                        if (flush_reg)
                        begin
                            frames_received_next = '0;
                            frames_emitted_next  = '0;
                            seq_count_next       = '0;
                            flush_next           = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SUMSQ:
            begin
                sumsq_next = sumsq_reg + SQS_W'(j_reg) * SQS_W'(j_reg);
                if (j_reg == n_reg)
                begin
                    j_next     = HW_W'(1);
                    state_next = ST_DRD;
                end
                else
                begin
                    j_next = j_reg + HW_W'(1);
                end
            end
            ST_DRD:
            begin
                state_next = ST_DACC;
            end
            ST_DACC:
            begin
                s_acc_next = s_acc_reg + S_W'(prod);
                if (j_reg == n_reg)
                begin
                    state_next = ST_DPREP;
                end
                else
                begin
                    j_next     = j_reg + HW_W'(1);
                    state_next = ST_DRD;
                end
            end
            ST_DPREP:
            begin
                // Adding half the divisor rounds the quotient to nearest, ties away from zero.
                num_next     = NUM_W'(mag) + NUM_W'(sumsq_reg);
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next     = div_ge ? DV_W'(div_shift - {1'b0, sumsq_reg, 1'b0})
                                      : DV_W'(div_shift);
                num_next     = {num_reg[NUM_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + DC_W'(1);
                if (div_cnt_reg == DC_W'(NUM_W - 1))
                begin
                    sq_in_next = SQI_W'({num_reg[NUM_W-2:0], div_ge});
                    xmode_next = 1'b0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                sq_next    = sq_in_reg * sq_in_reg;
                state_next = xmode_reg ? ST_XADD : ST_PADD;
            end
            ST_PADD:
            begin
                power_next = power_reg + PACC_W'(sq_reg);
                if (k_reg == nc_eff_reg)
                begin
                    k_next     = first_k;
                    pass_next  = 1'b0;
                    dacc_next  = '0;
                    state_next = ST_XRD;
                end
                else
                begin
                    k_next     = k_reg + WORD_W'(1);
                    j_next     = HW_W'(1);
                    s_acc_next = '0;
                    state_next = ST_DRD;
                end
            end
            ST_XRD:
            begin
                state_next = ST_XDIF;
            end
            ST_XDIF:
            begin
                sq_in_next = diff[DIFF_W-1] ? SQI_W'(-diff) : SQI_W'(diff);
                xmode_next = 1'b1;
                state_next = ST_SQ;
            end
            ST_XADD:
            begin
                dacc_next = dacc_reg + DACC_W'(sq_reg);
                if (k_reg == nc_eff_reg)
                begin
                    rad_next      = RAD_W'(dacc_reg + DACC_W'(sq_reg));
                    rrem_next     = '0;
                    root_next     = '0;
                    root_cnt_next = '0;
                    state_next    = ST_ROOT;
                end
                else
                begin
                    k_next     = k_reg + WORD_W'(1);
                    state_next = ST_XRD;
                end
            end
            ST_ROOT:
            begin
                rrem_next     = root_ge ? root_shift - root_trial : root_shift;
                root_next     = {root_reg[ROOT_W-2:0], root_ge};
                rad_next      = rad_reg << 2;
                root_cnt_next = root_cnt_reg + RC_W'(1);
                if (root_cnt_reg == RC_W'(ROOT_W - 1))
                begin
                    dist_sum_next = dist_sum_reg
                                  + (ROOT_W + 1)'({root_reg[ROOT_W-2:0], root_ge});
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        k_next     = first_k;
                        dacc_next  = '0;
                        state_next = ST_XRD;
                    end
                    else
                    begin
                        emit_next  = 1'b1;
                        state_next = ST_NEXT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            half_window_reg     <= HALF_WINDOW_RESET;
            include_energy_reg  <= 1'b0;
            num_coefs_reg       <= NUM_COEFS_RESET;
            newest_reg          <= '0;
            frame_open_reg      <= 1'b0;
            frames_received_reg <= '0;
            frames_emitted_reg  <= '0;
            seq_count_reg       <= '0;
            flush_reg           <= 1'b0;
            emit_reg            <= 1'b0;
            result_valid_reg    <= 1'b0;
            clr_cnt_reg         <= '0;
            div_cnt_reg         <= '0;
            root_cnt_reg        <= '0;
            j_reg               <= '0;
            k_reg               <= '0;
            pass_reg            <= 1'b0;
            xmode_reg           <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            half_window_reg     <= half_window_next;
            include_energy_reg  <= include_energy_next;
            num_coefs_reg       <= num_coefs_next;
            newest_reg          <= newest_next;
            frame_open_reg      <= frame_open_next;
            frames_received_reg <= frames_received_next;
            frames_emitted_reg  <= frames_emitted_next;
            seq_count_reg       <= seq_count_next;
            flush_reg           <= flush_next;
            emit_reg            <= emit_next;
            result_valid_reg    <= result_valid_next;
            clr_cnt_reg         <= clr_cnt_next;
            div_cnt_reg         <= div_cnt_next;
            root_cnt_reg        <= root_cnt_next;
            j_reg               <= j_next;
            k_reg               <= k_next;
            pass_reg            <= pass_next;
            xmode_reg           <= xmode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hw_eff_reg   <= hw_eff_next;
        nc_eff_reg   <= nc_eff_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        eos_reg      <= eos_next;
        back_reg     <= back_next;
        n_reg        <= n_next;
        fin_reg      <= fin_next;
        sumsq_reg    <= sumsq_next;
        s_acc_reg    <= s_acc_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        sq_in_reg    <= sq_in_next;
        sq_reg       <= sq_next;
        power_reg    <= power_next;
        dacc_reg     <= dacc_next;
        rad_reg      <= rad_next;
        rrem_reg     <= rrem_next;
        root_reg     <= root_next;
        dist_sum_reg <= dist_sum_next;
        result_reg   <= result_next;
    end

`ifndef SYNTHESIS
    a_pending_fits_ring: assert property (@(posedge clk) disable iff (!rst_n)
        int'(frames_received_reg - frames_emitted_reg) <= MAX_HALF_WINDOW + 1)
        else $error("more frames pending than the ring can hold");

    a_window_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRD) |-> (int'(back_reg) + int'(j_reg) < RING)
                                  && (j_reg <= back_reg))
        else $error("regression window reaches outside the frame ring");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_reg && (!result_valid_reg || result_ready)) |=> result_valid_reg && !emit_reg)
        else $error("finished result was not moved into the output register");
`endif

endmodule

// File: verif/cdsc_checker.sv
// Checker that predicts and compares the results of the cepstral delta core.
module cdsc_checker
    import cdsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   coef_valid,
    input  logic                   coef_ready,
    input  coef_item_t             coef,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  result_item_t           result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HW = 16;
    localparam int MAX_NC = 16;
    localparam int RING = 2 * MAX_HW + 1;

    longint frame_store [RING][MAX_NC+1];
    logic [23:0] frames_in;
    logic [23:0] frames_out;
    int          newest;
    int          seq_len;
    bit          assembling;
    logic [4:0]  reg_half_window;
    logic        reg_energy;
    logic [4:0]  reg_num_coefs;
    result_item_t expected_results [$];

    assign pending = expected_results.size();

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint coef_at(int back, int k);
        return frame_store[(newest + RING - (back % RING)) % RING][k];
    endfunction

    function automatic longint unsigned frame_distance(int a, int b, int first, int nc);
        longint unsigned acc;
        longint d;
        acc = 0;
        for (int k = first; k <= nc; k++)
        begin
            d = coef_at(a, k) - coef_at(b, k);
            if (d < 0) d = -d;
            acc = sat_add(acc, longint'(d) * longint'(d));
        end
        return int_sqrt(acc);
    endfunction

    function automatic result_item_t frame_result(int back, int left, int hw, int nc, bit fin);
        result_item_t r;
        longint unsigned power;
        longint unsigned stab;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned d;
        longint s;
        int first;
        int n;
        first = reg_energy ? 0 : 1;
        power = 0;
        stab = 0;
        if (left != 0 && back != 0)
        begin
            n = hw;
            if (left < n) n = left;
            if (back < n) n = back;
            den = longint'(n) * (n + 1) * (2 * n + 1) / 3;
            for (int k = first; k <= nc; k++)
            begin
                s = 0;
                for (int j = 1; j <= n; j++)
                    s += j * (coef_at(back - j, k) - coef_at(back + j, k));
                mag = (s < 0) ? -s : s;
                d = (mag + den / 2) / den;
                power = sat_add(power, d * d);
            end
            if (power > 48'hFFFF_FFFF_FFFF) power = 48'hFFFF_FFFF_FFFF;
            stab = (frame_distance(back, back + 1, first, nc) +
                    frame_distance(back, back - 1, first, nc)) / 2;
            if (stab > 32'hFFFF_FFFF) stab = 32'hFFFF_FFFF;
        end
        r.frame_number = frames_out;
        r.delta_power  = power[47:0];
        r.stability    = stab[31:0];
        r.final_result = fin;
        return r;
    endfunction

    task automatic predict_request(coef_item_t item);
        int hw;
        int nc;
        int idx;
        int p;
        int back;
        int left;
        int lag;
        int produced;
        bit eos;
        hw = (reg_half_window < 1) ? 1 : (reg_half_window > MAX_HW ? MAX_HW : reg_half_window);
        nc = (reg_num_coefs > MAX_NC) ? MAX_NC : reg_num_coefs;
        idx = item.coef_index;
        eos = item.end_of_sequence;
        produced = 0;
        if (idx > nc && !eos) return;
        if (!assembling)
        begin
            newest = (newest + 1) % RING;
            for (int k = 0; k <= MAX_NC; k++) frame_store[newest][k] = 0;
            assembling = 1;
        end
        if (idx <= nc) frame_store[newest][idx] = item.coef_value;
        if (idx != nc && !eos) return;
        frames_in = frames_in + 1;
        if (seq_len < 65535) seq_len++;
        assembling = 0;
        forever
        begin
            p = 24'(frames_in - frames_out);
            if (p == 0 || produced >= 17) break;
            back = p - 1;
            left = (seq_len >= p) ? seq_len - p : 0;
            lag = (left == 0) ? 1 : (left < hw ? left : hw);
            if (!eos && back < lag) break;
            expected_results.push_back(frame_result(back, left, hw, nc, eos && back == 0));
            frames_out = frames_out + 1;
            produced++;
        end
        if (eos)
        begin
            frames_in = 0;
            frames_out = 0;
            seq_len = 0;
        end
    endtask

    task automatic report(string field, longint unsigned got, longint unsigned want);
        $display("%0t: %s got %0d, expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_item_t want;
        if (!rst_n)
        begin
            frames_in = 0;
            frames_out = 0;
            newest = 0;
            seq_len = 0;
            assembling = 0;
            reg_half_window = HALF_WINDOW_RESET;
            reg_energy = 0;
            reg_num_coefs = NUM_COEFS_RESET;
            errors = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HALF_WINDOW:    reg_half_window = cfg_data;
                    CFG_INCLUDE_ENERGY: reg_energy = cfg_data[0];
                    CFG_NUM_COEFS:      reg_num_coefs = cfg_data;
                    default: ;
                endcase
            end
            if (coef_valid && coef_ready) predict_request(coef);
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                    report("unexpected result, frame_number", result.frame_number, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.frame_number !== want.frame_number)
                        report("frame_number", result.frame_number, want.frame_number);
                    if (result.delta_power !== want.delta_power)
                        report("delta_power", result.delta_power, want.delta_power);
                    if (result.stability !== want.stability)
                        report("stability", result.stability, want.stability);
                    if (result.final_result !== want.final_result)
                        report("final_result", result.final_result, want.final_result);
                end
            end
        end
    end
endmodule

// File: verif/cepstral_delta_and_stability_core_tb.sv
// Testbench top that drives the cepstral delta core and gives the verdict.
module cepstral_delta_and_stability_core_tb;
    import cdsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE = 300;

    logic clk;
    logic rst_n;
    logic coef_valid;
    logic coef_ready;
    coef_item_t coef;
    logic result_valid;
    logic result_ready;
    result_item_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int errors;
    int pending;
    int items_sent;
    int active_coefs;
    bit long_hold;
    int quiet_cycles;

    cepstral_delta_and_stability_core DUT (
        .clk(clk), .rst_n(rst_n),
        .coef_valid(coef_valid), .coef_ready(coef_ready), .coef(coef),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cdsc_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .coef_valid(coef_valid), .coef_ready(coef_ready), .coef(coef),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (coef_valid && coef_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("cepstral_delta_and_stability_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        int gap;
        result_ready = 0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (long_hold)
            begin
                gap = 400;
                long_hold = 0;
            end
            repeat (gap) @(negedge clk) result_ready <= 0;
            @(negedge clk) result_ready <= 1;
            do @(posedge clk); while (!result_valid);
        end
    end

    task automatic send_coef(logic signed [COEF_BITS-1:0] value, int idx, bit eos);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk) coef_valid <= 0;
        @(negedge clk);
        coef_valid <= 1;
        coef.coef_value <= value;
        coef.coef_index <= idx[INDEX_W-1:0];
        coef.end_of_sequence <= eos;
        do @(posedge clk); while (!coef_ready);
        items_sent++;
        @(negedge clk) coef_valid <= 0;
    endtask

    function automatic logic signed [COEF_BITS-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(COEF_BITS-1){1'b0}}};
            1: return {1'b0, {(COEF_BITS-1){1'b1}}};
            2: return COEF_BITS'($urandom_range(0, 8191)) - COEF_BITS'(4096);
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    task automatic send_frame(bit last_frame);
        for (int i = 0; i <= active_coefs; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_coef(pick_value(), $urandom_range(active_coefs + 1, 31), 0);
            send_coef(pick_value(), i, last_frame && i == active_coefs);
        end
    endtask

    task automatic send_sequence(int frames);
        for (int f = 0; f < frames; f++) send_frame(f == frames - 1);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk) cfg_valid <= 0;
    endtask

    task automatic configure(int hw, int energy, int nc);
        write_reg(CFG_HALF_WINDOW, hw[4:0]);
        write_reg(CFG_INCLUDE_ENERGY, energy[4:0]);
        write_reg(CFG_NUM_COEFS, nc[4:0]);
        active_coefs = (nc > 16) ? 16 : nc;
    endtask

    initial
    begin
        int frames;
        rst_n = 0;
        coef_valid = 0;
        coef = '0;
        cfg_valid = 0;
        cfg_index = CFG_HALF_WINDOW;
        cfg_data = '0;
        items_sent = 0;
        long_hold = 0;
        quiet_cycles = 0;
        active_coefs = 12;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1;

        configure(1, 1, 1);
        send_coef(24'sh7FFFFF, 0, 1);
        send_coef(24'sh800000, 0, 0);
        send_coef(24'sh7FFFFF, 1, 0);
        send_coef(24'sh000000, 31, 0);
        send_coef(24'sh800000, 0, 0);
        send_coef(24'sh800000, 1, 0);
        send_coef(24'sh7FFFFF, 0, 0);
        send_coef(24'sh7FFFFF, 1, 0);
        send_coef(24'sh123456, 0, 1);
        send_coef(24'sh000FFF, 0, 0);
        send_coef(24'shFFF000, 1, 0);
        send_coef(24'sh0AAAAA, 0, 0);
        send_coef(24'sh555555, 17, 1);
        send_coef(24'sh000001, 0, 0);
        send_coef(24'shFFFFFF, 1, 0);
        send_coef(24'sh400000, 0, 0);
        send_coef(24'sh3FFFFF, 1, 1);

        configure(16, 0, 16);
        send_sequence(3);
        configure(0, 1, 0);
        send_sequence(6);
        configure(31, 1, 31);
        send_sequence(2);
        configure(16, 1, 0);
        send_sequence(36);
        configure(2, 0, 4);
        long_hold = 1;
        send_sequence(4);

        while (items_sent < 170)
        begin
            configure($urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 6));
            repeat ($urandom_range(1, 2))
            begin
                frames = $urandom_range(1, 4);
                for (int f = 0; f < frames; f++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        while (pending != 0) @(posedge clk);
                    send_frame(f == frames - 1);
                end
            end
            if ($urandom_range(0, 2) == 0)
                send_coef(pick_value(), $urandom_range(0, active_coefs), 1);
        end

        @(negedge clk) coef_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("cepstral_delta_and_stability_core: match");
        else
            $display("cepstral_delta_and_stability_core: mismatch");
        $finish;
    end
endmodule
